// ===== rtl/ptes_pkg.sv =====
// Shared types and constants of the periodic timer event scheduler.
// Holds the table sizes, operation and status codes and the structs that run
// between the sequencer, the shared arithmetic unit and the slot memory.
`default_nettype none

package ptes_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SID_W       = 4;
    localparam int DUE_W       = 32;
    localparam int PERIOD_W    = 32;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_REMOVE_ALL = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_REGISTERED  = 3'd0,
        ST_FULL        = 3'd1,
        ST_REMOVED     = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_ALL_REMOVED = 3'd4,
        ST_FIRED       = 3'd5
    } status_t;

    // Request to the shared adder / subtractor and comparator.
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
        logic [TIME_W-1:0] cmp_ref;
    } alu_req_t;

    // Write request to the slot memory.
    typedef struct packed {
        logic              due_en;
        logic              per_en;
        logic [SLOT_W-1:0] addr;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] per;
    } ram_wr_t;

endpackage

`default_nettype wire

// ===== rtl/ptes_alu.sv =====
// Shared arithmetic unit: one add or subtract followed by an unsigned compare.
// Depends on ptes_pkg for the time width and the request struct.
`default_nettype none

module ptes_alu
    import ptes_pkg::*;
(
    input  alu_req_t          req,
    output logic [TIME_W-1:0] sum,
    output logic              gt
);

    logic [TIME_W-1:0] b_eff;

    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = req.a + b_eff + {{(TIME_W-1){1'b0}}, req.sub};
    // True when the result is strictly above the reference value.
    assign gt    = (sum > req.cmp_ref);

endmodule

`default_nettype wire

// ===== rtl/ptes_slot_ram.sv =====
// Slot memory: due time and repeat period of every timer slot.
// One write port and one registered read port; depends on ptes_pkg.
`default_nettype none

module ptes_slot_ram
    import ptes_pkg::*;
(
    input  logic              clk,
    input  ram_wr_t           wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [TIME_W-1:0] rd_due,
    output logic [TIME_W-1:0] rd_per
);

    logic [TIME_W-1:0] due_mem [TIMER_SLOTS];
    logic [TIME_W-1:0] per_mem [TIMER_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.due_en)
        begin
            due_mem[wr.addr] <= wr.due;
        end
        if (wr.per_en)
        begin
            per_mem[wr.addr] <= wr.per;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_due <= due_mem[rd_addr];
        rd_per <= per_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_event_scheduler_top.sv =====
// Top level of the periodic timer event scheduler: sequencer, slot flags and
// output register. Depends on ptes_pkg, ptes_alu and ptes_slot_ram.
//
//  channel  | direction | tuser       | tdata                                      | tlast
//  s_axis   | in        | op          | slot_id, start_delay, repeat_period        | -
//  m_axis   | out       | status      | result_slot, due_time                      | last
//
// Operation: one request at a time. Register walks the slots in turn in its
// free-slot search. A tick makes a full pass over the slot memory for each
// firing and a closing empty pass, which is skipped when MAX_RESULTS slots
// fire: each pass goes through the single read port of the slot memory, with
// the shared subtractor and comparator judging one slot per cycle.
// Reset clears the clock, the active flags and all control state; the slot
// memory is not cleared, as an entry is written before its slot turns active.
// A stalled output holds its result; the sequencer waits only when it has a
// further result to hand over.
`default_nettype none

module periodic_timer_event_scheduler_top
    import ptes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // op
    input  logic [71:0] s_axis_tdata,   // slot_id, start_delay, repeat_period, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [2:0]  m_axis_tuser,   // status
    output logic [39:0] m_axis_tdata,   // result_slot, due_time, zero pad
    output logic        m_axis_tlast    // last
);

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_REG_SCAN  = 10'b00_0000_0010,
        S_REG_END   = 10'b00_0000_0100,
        S_SIMPLE    = 10'b00_0000_1000,
        S_TICK      = 10'b00_0001_0000,
        S_SCAN      = 10'b00_0010_0000,
        S_SCAN_TAIL = 10'b00_0100_0000,
        S_DECIDE    = 10'b00_1000_0000,
        S_REARM     = 10'b01_0000_0000,
        S_FLUSH     = 10'b10_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [TIMER_SLOTS-1:0] taken_reg, taken_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   best_vld_reg, best_vld_next;
    logic [CNT_W-1:0]       fired_reg, fired_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic                   out_vld_reg;

    // Payload registers, no reset.
    op_t                    op_reg, op_next;
    logic [SID_W-1:0]       sid_reg, sid_next;
    logic [TIME_W-1:0]      delay_reg, delay_next;
    logic [TIME_W-1:0]      period_reg, period_next;
    logic [SLOT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]      best_late_reg, best_late_next;
    logic [TIME_W-1:0]      best_due_reg, best_due_next;
    logic [SLOT_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [TIME_W-1:0]      pend_due_reg, pend_due_next;
    status_t                out_status_reg;
    logic [SID_W-1:0]       out_slot_reg;
    logic [DUE_W-1:0]       out_due_reg;
    logic                   out_last_reg;

    // Result handed to the output register this cycle.
    logic                   emit;
    status_t                emit_status;
    logic [SID_W-1:0]       emit_slot;
    logic [TIME_W-1:0]      emit_due;
    logic                   emit_last;
    logic                   can_emit;

    alu_req_t               alu_req;
    logic [TIME_W-1:0]      alu_sum;
    logic                   alu_gt;
    ram_wr_t                ram_wr;
    logic [SLOT_W-1:0]      ram_rd_addr;
    logic [TIME_W-1:0]      ram_due;
    logic [TIME_W-1:0]      ram_per;

    logic                   in_accept;
    logic                   idx_last;
    logic                   cand;
    logic                   sid_ok;

    ptes_alu u_alu (
        .req (alu_req),
        .sum (alu_sum),
        .gt  (alu_gt)
    );

    ptes_slot_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_due  (ram_due),
        .rd_per  (ram_per)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign can_emit      = !out_vld_reg || m_axis_tready;
    assign idx_last      = (idx_reg == SLOT_W'(TIMER_SLOTS - 1));

    // A slot seen in the scan competes when it is active, has not fired in this
    // tick and its lateness is not negative.
    assign cand   = active_reg[rd_idx_reg] && !taken_reg[rd_idx_reg] && !alu_sum[TIME_W-1];
    assign sid_ok = (int'(sid_reg) < TIMER_SLOTS) && active_reg[SLOT_W'(sid_reg)];

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        active_next    = active_reg;
        taken_next     = taken_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rd_vld_next    = (state_reg == S_SCAN);
        rd_idx_next    = idx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_late_next = best_late_reg;
        best_due_next  = best_due_reg;
        fired_next     = fired_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        pend_due_next  = pend_due_reg;
        op_next        = op_reg;
        sid_next       = sid_reg;
        delay_next     = delay_reg;
        period_next    = period_reg;

        emit           = 1'b0;
        emit_status    = ST_FIRED;
        emit_slot      = '0;
        emit_due       = '0;
        emit_last      = 1'b0;

        alu_req.a       = now_reg;
        alu_req.b       = ram_due;
        alu_req.sub     = 1'b1;
        alu_req.cmp_ref = best_late_reg;

        ram_wr.due_en  = 1'b0;
        ram_wr.per_en  = 1'b0;
        ram_wr.addr    = idx_reg;
        ram_wr.due     = alu_sum;
        ram_wr.per     = period_reg;
        ram_rd_addr    = idx_reg;

        // Scan evaluation: data of the slot read in the previous cycle.
        if (rd_vld_reg && cand && (!best_vld_reg || alu_gt))
        begin
            best_vld_next  = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_late_next = alu_sum;
            best_due_next  = ram_due;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = op_t'(s_axis_tuser);
                    sid_next    = s_axis_tdata[3:0];
                    delay_next  = TIME_W'(s_axis_tdata[35:4]);
                    period_next = TIME_W'(s_axis_tdata[67:36]);
                    idx_next    = '0;
                    case (op_t'(s_axis_tuser))
                        OP_REGISTER:   state_next = S_REG_SCAN;
                        OP_REMOVE:     state_next = S_SIMPLE;
                        OP_REMOVE_ALL: state_next = S_SIMPLE;
                        OP_TICK:       state_next = S_TICK;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end

            S_REG_SCAN:
            begin
                if (!active_reg[idx_reg])
                begin
                    found_next = 1'b1;
                    state_next = S_REG_END;
                end
                else if (idx_last)
                begin
                    found_next = 1'b0;
                    state_next = S_REG_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_REG_END:
            begin
                alu_req.a   = now_reg;
                alu_req.b   = delay_reg;
                alu_req.sub = 1'b0;
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (found_reg)
                    begin
                        ram_wr.due_en        = 1'b1;
                        ram_wr.per_en        = 1'b1;
                        active_next[idx_reg] = 1'b1;
                        emit_status          = ST_REGISTERED;
                        emit_slot            = SID_W'(idx_reg);
                        emit_due             = alu_sum;
                    end
                    else
                    begin
                        emit_status = ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SIMPLE:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (op_reg == OP_REMOVE)
                    begin
                        emit_slot = sid_reg;
                        if (sid_ok)
                        begin
                            active_next[SLOT_W'(sid_reg)] = 1'b0;
                            emit_status                   = ST_REMOVED;
                        end
                        else
                        begin
                            emit_status = ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        active_next = '0;
                        emit_status = ST_ALL_REMOVED;
                    end
                    state_next = S_IDLE;
                end
            end

            S_TICK:
            begin
                alu_req.a     = now_reg;
                alu_req.b     = TIME_W'(1);
                alu_req.sub   = 1'b0;
                now_next      = alu_sum;
                taken_next    = '0;
                fired_next    = '0;
                pend_vld_next = 1'b0;
                idx_next      = '0;
                best_vld_next = 1'b0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = S_SCAN_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_SCAN_TAIL:
            begin
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                ram_rd_addr = best_idx_reg;
                if (!best_vld_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!pend_vld_reg || can_emit)
                begin
                    // The previous firing is known now not to be the final one.
                    if (pend_vld_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FIRED;
                        emit_slot   = SID_W'(pend_slot_reg);
                        emit_due    = pend_due_reg;
                        emit_last   = 1'b0;
                    end
                    pend_vld_next            = 1'b1;
                    pend_slot_next           = best_idx_reg;
                    pend_due_next            = best_due_reg;
                    taken_next[best_idx_reg] = 1'b1;
                    fired_next               = fired_reg + 1'b1;
                    state_next               = S_REARM;
                end
            end

            S_REARM:
            begin
                alu_req.a   = best_due_reg;
                alu_req.b   = ram_per;
                alu_req.sub = 1'b0;
                ram_wr.addr = best_idx_reg;
                if (ram_per != '0)
                begin
                    ram_wr.due_en = 1'b1;
                end
                else
                begin
                    active_next[best_idx_reg] = 1'b0;
                end
                if (fired_reg == CNT_W'(MAX_RESULTS))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    emit          = 1'b1;
                    emit_status   = ST_FIRED;
                    emit_slot     = SID_W'(pend_slot_reg);
                    emit_due      = pend_due_reg;
                    emit_last     = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            active_reg   <= '0;
            taken_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            fired_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            active_reg   <= active_next;
            taken_reg    <= taken_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            rd_vld_reg   <= rd_vld_next;
            best_vld_reg <= best_vld_next;
            fired_reg    <= fired_next;
            pend_vld_reg <= pend_vld_next;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sid_reg       <= sid_next;
        delay_reg     <= delay_next;
        period_reg    <= period_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_late_reg <= best_late_next;
        best_due_reg  <= best_due_next;
        pend_slot_reg <= pend_slot_next;
        pend_due_reg  <= pend_due_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_slot_reg   <= emit_slot;
            out_due_reg    <= DUE_W'(emit_due);
            out_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'b0000, out_due_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

    // No firing may be left pending once the sequencer is back at rest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_vld_reg)
        else $error("pending firing left over at idle");

    // Every accepted request keeps the block busy: the input is not ready in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request accepted without leaving idle");

    // The chosen slot must be active and must not have fired in this tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && best_vld_reg) |->
            (active_reg[best_idx_reg] && !taken_reg[best_idx_reg]))
        else $error("scan picked an inactive or already fired slot");

endmodule

`default_nettype wire
